// File: rtl/core/rsp_pkg.sv
// Shared types, codes and constants of the run-length sprite palette decoder.
package rsp_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int COORD_W         = 13;
  localparam int ADDR_W          = 24;
  localparam int PROD_W          = 2 * COORD_W;

  // Input opcodes
  localparam logic OP_BODY    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;
  localparam logic [1:0] REG_EOR    = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] image_width;
    logic [COORD_W-1:0] image_height;
    logic [7:0]         end_marker_code;
    logic [7:0]         end_of_row_code;
  } cfg_t;

  // Stage-0 outcome of one accepted byte, handed to the result pipeline
  typedef struct packed {
    logic               has_result;
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  prod;
    logic [COORD_W-1:0] column;
    logic [7:0]         run_length;
    logic               oob;
  } step_t;

endpackage

// File: rtl/core/rsp_cfg.sv
// APB register file holding width, height and the two control codes.
module rsp_cfg
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [COORD_W-1:0] width_raw;
  logic [COORD_W-1:0] width_next;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Clamp a width write into 1..MAX_WIDTH
  assign width_raw = pwdata[COORD_W-1:0];
  always_comb begin
    if (width_raw == '0) begin
      width_next = COORD_W'(1);
    end else if (width_raw > COORD_W'(MAX_WIDTH)) begin
      width_next = COORD_W'(MAX_WIDTH);
    end else begin
      width_next = width_raw;
    end
  end

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= COORD_W'(1);
      cfg.image_height    <= COORD_W'(1);
      cfg.end_marker_code <= 8'd255;
      cfg.end_of_row_code <= 8'd254;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg.image_width     <= width_next;
        REG_HEIGHT: cfg.image_height    <= pwdata[COORD_W-1:0];
        REG_END:    cfg.end_marker_code <= pwdata[7:0];
        REG_EOR:    cfg.end_of_row_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(cfg.image_width);
      REG_HEIGHT: prdata = 32'(cfg.image_height);
      REG_END:    prdata = 32'(cfg.end_marker_code);
      REG_EOR:    prdata = 32'(cfg.end_of_row_code);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/rsp_palette.sv
// Palette memory: one write port, one registered read port with hold.
module rsp_palette
  import rsp_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PAL_AW-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [PAL_AW-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [PALETTE_ENTRIES];

  // Store color
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read color; hold while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/rsp_parser.sv
// Body parser: phase, column, row and pixel count, one byte per cycle while accept is high.
module rsp_parser
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output step_t      step
);

  localparam logic [1:0] PH_COUNT    = 2'd0;
  localparam logic [1:0] PH_PIXCOUNT = 2'd1;
  localparam logic [1:0] PH_PIXELS   = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [COORD_W-1:0] column, column_next;
  logic [COORD_W-1:0] row, row_next;
  logic [7:0]         pixels_left, pixels_left_next;

  logic [COORD_W:0]   col_run_sum;
  logic [COORD_W-1:0] col_run_sat;
  logic [COORD_W-1:0] col_inc_sat;
  logic [COORD_W-1:0] row_inc_sat;
  logic [PROD_W-1:0]  prod_full;
  logic               row_oob;
  logic [7:0]         left_dec;

  assign col_run_sum = {1'b0, column} + (COORD_W+1)'(data_byte);
  assign col_run_sat = col_run_sum[COORD_W] ? '1 : col_run_sum[COORD_W-1:0];
  assign col_inc_sat = (&column) ? column : column + COORD_W'(1);
  assign row_inc_sat = (&row) ? row : row + COORD_W'(1);
  assign prod_full   = PROD_W'(row) * PROD_W'(cfg.image_width);
  assign row_oob     = row >= cfg.image_height;
  assign left_dec    = pixels_left - 8'd1;

  // Decode one body byte against the current phase
  always_comb begin
    phase_next       = phase;
    column_next      = column;
    row_next         = row;
    pixels_left_next = pixels_left;
    step.has_result  = 1'b0;
    step.kind        = KIND_RUN;
    step.prod        = prod_full[ADDR_W-1:0];
    step.column      = column;
    step.run_length  = data_byte;
    step.oob         = 1'b0;
    if (accept && opcode == OP_BODY) begin
      unique case (phase)
        PH_PIXCOUNT: begin
          pixels_left_next = data_byte;
          phase_next       = (data_byte == 8'd0) ? PH_COUNT : PH_PIXELS;
        end
        PH_PIXELS: begin
          step.has_result  = 1'b1;
          step.kind        = KIND_PIXEL;
          step.run_length  = 8'd1;
          step.oob         = (column >= cfg.image_width) || row_oob;
          column_next      = col_inc_sat;
          pixels_left_next = left_dec;
          if (left_dec == 8'd0) begin
            phase_next = PH_COUNT;
          end
        end
        default: begin
          if (data_byte == cfg.end_marker_code) begin
            step.has_result  = 1'b1;
            step.kind        = KIND_END;
            step.prod        = '0;
            step.column      = '0;
            step.run_length  = 8'd0;
            column_next      = '0;
            row_next         = '0;
            pixels_left_next = 8'd0;
            phase_next       = PH_COUNT;
          end else if (data_byte == cfg.end_of_row_code) begin
            column_next = '0;
            row_next    = row_inc_sat;
            phase_next  = PH_COUNT;
          end else begin
            step.has_result = 1'b1;
            step.kind       = KIND_RUN;
            step.oob        = row_oob || (col_run_sum > (COORD_W+1)'(cfg.image_width));
            column_next     = col_run_sat;
            phase_next      = PH_PIXCOUNT;
          end
        end
      endcase
    end
  end

  // Advance walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COUNT;
      column      <= '0;
      row         <= '0;
      pixels_left <= 8'd0;
    end else begin
      phase       <= phase_next;
      column      <= column_next;
      row         <= row_next;
      pixels_left <= pixels_left_next;
    end
  end

endmodule

// File: rtl/core/rle_sprite_palette_decoder.sv
// Top level of the run-length sprite decoder with palette lookup.
//
// Input channel (item_valid / item_stall): one request per cycle, when not stalled, carries
// opcode, data_byte and palette_color. A palette request stores
// palette_color at entry data_byte and gives no result. A body request
// steps the parser; runs, colored pixels and the end marker give one result.
// Output channel (result_valid / result_stall): kind, pixel_address,
// run_length, pixel_color and out_of_bounds.
// A result passes the read stage, which registers the palette memory read
// and row * width, and then the output register, which adds the column and
// selects the color.
// Throughput: one request per cycle while the output is not stalled.
// When the receiver stalls a valid result, the output register and the read stage hold,
// and item_stall rises in the same cycle, so nothing enters while a
// result waits.
// Reset clears phase, column, row, pixel count, configuration and the valid
// flags; palette contents are undefined until written. The user writes APB
// configuration only when no request is in flight; the block does not check.
module rle_sprite_palette_decoder
  import rsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              opcode,
  input  logic [7:0]        data_byte,
  input  logic [31:0]       palette_color,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        kind,
  output logic [ADDR_W-1:0] pixel_address,
  output logic [7:0]        run_length,
  output logic [31:0]       pixel_color,
  output logic              out_of_bounds
);

  cfg_t        cfg;
  step_t       step;
  step_t       s1;
  logic        s1_valid;
  logic        advance;
  logic        accept;
  logic [31:0] pal_data;

  // Move the pipeline whenever the output register is free or drained
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  rsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .data_byte (data_byte),
    .cfg       (cfg),
    .step      (step)
  );

  rsp_palette u_palette (
    .clk     (clk),
    .wr_en   (accept && opcode == OP_PALETTE),
    .wr_addr (data_byte[PAL_AW-1:0]),
    .wr_data (palette_color),
    .rd_en   (advance),
    .rd_addr (data_byte[PAL_AW-1:0]),
    .rd_data (pal_data)
  );

  // Read stage: hold the request while the palette read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && step.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= step;
    end
  end

  // Output register: finish the address and pick the color
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind          <= s1.kind;
      pixel_address <= s1.prod + ADDR_W'(s1.column);
      run_length    <= s1.run_length;
      pixel_color   <= (s1.kind == KIND_PIXEL) ? pal_data : 32'd0;
      out_of_bounds <= s1.oob;
    end
  end

endmodule

// File: tb/rle_sprite_palette_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the run-length sprite decoder with palette lookup.
module rle_sprite_palette_decoder_test;
  import rsp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_WAIT    = 18;
  localparam int PHASE_ITEMS = 60;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;

  typedef enum logic [1:0] {WANT_RUN, WANT_PIXCOUNT, WANT_PIXELS} parse_phase_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  data_byte;
    logic [31:0] palette_color;
  } body_request_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        run_length;
    logic [31:0]       pixel_color;
    logic              out_of_bounds;
  } sprite_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              opcode = OP_BODY;
  logic [7:0]        data_byte = '0;
  logic [31:0]       palette_color = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] pixel_address;
  logic [7:0]        run_length;
  logic [31:0]       pixel_color;
  logic              out_of_bounds;

  // Shadow of the decoder: registers, parser position and palette
  int unsigned  cfg_width = 1;
  int unsigned  cfg_height = 1;
  logic [7:0]   cfg_end_code = 8'd255;
  logic [7:0]   cfg_eor_code = 8'd254;
  parse_phase_e parse_phase = WANT_RUN;
  int unsigned  col_pos = 0;
  int unsigned  row_pos = 0;
  int unsigned  pix_left = 0;
  logic [31:0]  palette_shadow [PALETTE_ENTRIES];
  bit           pal_written [PALETTE_ENTRIES];
  logic [7:0]   written_idx [$];

  body_request_t  requests_to_send [$];
  sprite_result_t sprite_results_due [$];
  int             requests_queued = 0;
  int             error_count = 0;
  int             cycle_count = 0;

  // Handshake bookkeeping of driver and receiver
  logic           item_taken = 1'b0;
  logic           result_taken = 1'b0;
  bit             sender_calm = 1'b0;
  bit             receiver_calm = 1'b0;
  bit             long_hold_tog = 1'b0;
  bit             hold_seen = 1'b0;
  int             hold_left = 0;
  int             send_gap = 0;
  bit             gap_drawn = 1'b0;
  int             recv_gap = 0;
  body_request_t  out_req;
  sprite_result_t got;
  sprite_result_t want;

  rle_sprite_palette_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .palette_color(palette_color),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .pixel_address(pixel_address),
    .run_length   (run_length),
    .pixel_color  (pixel_color),
    .out_of_bounds(out_of_bounds)
  );

  always #4 clk = ~clk;

  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_WAIT) : $urandom_range(0, 3);
  endfunction

  function automatic int unsigned clip_coord(input int unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic logic [ADDR_W-1:0] pixel_addr();
    return ADDR_W'(row_pos * cfg_width + col_pos);
  endfunction

  // Decode one request in the shadow, then queue it and any result it gives
  task automatic queue_request(input logic op, input logic [7:0] b, input logic [31:0] color);
    body_request_t  req;
    sprite_result_t res;
    bit             produces;
    produces = 1'b0;
    res = '0;
    // keep pixel lookups on written palette entries
    if (op == OP_BODY && parse_phase == WANT_PIXELS && !pal_written[b])
      b = written_idx[$urandom_range(0, written_idx.size() - 1)];
    req.opcode = op;
    req.data_byte = b;
    req.palette_color = color;
    if (op == OP_PALETTE) begin
      if (!pal_written[b]) written_idx.insert(written_idx.size(), b);
      pal_written[b] = 1'b1;
      palette_shadow[b] = color;
    end else if (parse_phase == WANT_PIXCOUNT) begin
      pix_left = b;
      parse_phase = (b == 0) ? WANT_RUN : WANT_PIXELS;
    end else if (parse_phase == WANT_PIXELS) begin
      res.kind = KIND_PIXEL;
      res.pixel_address = pixel_addr();
      res.run_length = 8'd1;
      res.pixel_color = palette_shadow[b];
      res.out_of_bounds = (col_pos >= cfg_width) || (row_pos >= cfg_height);
      produces = 1'b1;
      col_pos = clip_coord(col_pos + 1);
      pix_left--;
      if (pix_left == 0) parse_phase = WANT_RUN;
    end else if (b == cfg_end_code) begin
      // end marker wins over the end-of-row code
      res.kind = KIND_END;
      produces = 1'b1;
      col_pos = 0;
      row_pos = 0;
      pix_left = 0;
      parse_phase = WANT_RUN;
    end else if (b == cfg_eor_code) begin
      col_pos = 0;
      row_pos = clip_coord(row_pos + 1);
    end else begin
      res.kind = KIND_RUN;
      res.pixel_address = pixel_addr();
      res.run_length = b;
      res.out_of_bounds = (row_pos >= cfg_height) || (col_pos + b > cfg_width);
      produces = 1'b1;
      col_pos = clip_coord(col_pos + b);
      parse_phase = WANT_PIXCOUNT;
    end
    if (produces) sprite_results_due.insert(sprite_results_due.size(), res);
    requests_to_send.insert(requests_to_send.size(), req);
    requests_queued++;
  endtask

  task automatic wait_drained();
    while (requests_to_send.size() != 0 || item_valid || sprite_results_due.size() != 0)
      @(posedge clk);
    // palette writes give no result and may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    int unsigned v;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    v = value & 32'h1FFF;
    case (idx)
      REG_WIDTH: begin
        if (v < 1) v = 1;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        cfg_width = v;
      end
      REG_HEIGHT: cfg_height = v;
      REG_END: cfg_end_code = value[7:0];
      REG_EOR: cfg_eor_code = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned e, input int unsigned r);
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_END, e);
    write_reg(REG_EOR, r);
  endtask

  // Run count that is neither control code
  function automatic logic [7:0] pick_count(input int run_max);
    int v;
    int tries;
    tries = 0;
    do begin
      v = (tries < 8) ? $urandom_range(0, run_max) : $urandom_range(0, 255);
      tries++;
    end while (v == cfg_end_code || v == cfg_eor_code);
    return 8'(v);
  endfunction

  // Well-formed sprite: rows of run / pixel-count / pixel segments
  task automatic gen_sprite(input int rows, input int seg_max, input int run_max,
                            input int pix_max);
    int npix;
    for (int r = 0; r < rows; r++) begin
      repeat ($urandom_range(1, seg_max)) begin
        queue_request(OP_BODY, pick_count(run_max), $urandom());
        npix = $urandom_range(0, pix_max);
        queue_request(OP_BODY, 8'(npix), $urandom());
        repeat (npix) queue_request(OP_BODY, 8'($urandom_range(0, 255)), $urandom());
      end
      if (r < rows - 1) queue_request(OP_BODY, cfg_eor_code, $urandom());
    end
    // now and then leave the sprite unterminated
    if ($urandom_range(0, 9) != 0) queue_request(OP_BODY, cfg_end_code, $urandom());
  endtask

  task automatic random_phase();
    int first;
    first = requests_queued;
    sender_calm = ($urandom_range(0, 3) == 0);
    receiver_calm = ($urandom_range(0, 3) == 0);
    while (requests_queued - first < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6))
             queue_request(OP_BODY, 8'($urandom_range(0, 255)), $urandom());
        1: repeat ($urandom_range(1, 4))
             queue_request(OP_PALETTE, 8'($urandom_range(0, 255)), $urandom());
        default: gen_sprite($urandom_range(1, 4), 3,
                            ($urandom_range(0, 3) == 0) ? 255 : 12,
                            ($urandom_range(0, 7) == 0) ? 40 : 5);
      endcase
    end
  endtask

  // Note accepted requests and results at the rising edge
  always @(posedge clk) begin
    item_taken <= item_valid && !item_stall;
    result_taken <= !rst && result_valid && !result_stall;
  end

  // Drive requests: hold while stalled, idle a drawn number of cycles between
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_taken) begin
      // hold the stalled request
    end else if (requests_to_send.size() == 0) begin
      item_valid <= 1'b0;
    end else begin
      if (!gap_drawn) begin
        send_gap = draw_wait(sender_calm);
        gap_drawn = 1'b1;
      end
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else begin
        out_req = requests_to_send.pop_front();
        opcode <= out_req.opcode;
        data_byte <= out_req.data_byte;
        palette_color <= out_req.palette_color;
        item_valid <= 1'b1;
        gap_drawn = 1'b0;
      end
    end
  end

  // Stall results: a drawn wait after each one, and a long hold on request
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_seen != long_hold_tog) begin
        hold_seen = long_hold_tog;
        hold_left = LONG_HOLD;
      end
      if (result_taken) recv_gap = draw_wait(receiver_calm);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got = {kind, pixel_address, run_length, pixel_color, out_of_bounds};
      if (sprite_results_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result at cycle %0d: kind %0d addr %06h len %0d color %08h oob %0d",
                   cycle_count, got.kind, got.pixel_address, got.run_length,
                   got.pixel_color, got.out_of_bounds);
      end else begin
        want = sprite_results_due.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected kind %0d addr %06h len %0d color %08h oob %0d",
                     want.kind, want.pixel_address, want.run_length,
                     want.pixel_color, want.out_of_bounds);
            $display("  actual   kind %0d addr %06h len %0d color %08h oob %0d",
                     got.kind, got.pixel_address, got.run_length,
                     got.pixel_color, got.out_of_bounds);
          end
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Palette extremes, then a few bytes under the reset registers
    queue_request(OP_PALETTE, 8'd0, 32'h0000_0000);
    queue_request(OP_PALETTE, 8'd255, 32'hFFFF_FFFF);
    queue_request(OP_PALETTE, 8'hAA, 32'h5555_AAAA);
    queue_request(OP_PALETTE, 8'h55, 32'hAAAA_5555);
    queue_request(OP_BODY, 8'd3, 32'hFFFF_FFFF);
    queue_request(OP_BODY, 8'd1, 32'h0);
    queue_request(OP_BODY, 8'hAA, 32'h0);
    queue_request(OP_BODY, 8'd255, 32'h0);

    // Zero run, pixels at both palette ends, exact-fit run, row and height edges
    configure(16, 2, 255, 254);
    queue_request(OP_BODY, 8'd0, 32'h0);
    queue_request(OP_BODY, 8'd2, 32'h0);
    queue_request(OP_BODY, 8'd0, 32'h0);
    queue_request(OP_BODY, 8'd255, 32'h0);
    queue_request(OP_BODY, 8'd5, 32'h0);
    queue_request(OP_BODY, 8'd1, 32'h0);
    queue_request(OP_BODY, 8'hAA, 32'h0);
    queue_request(OP_BODY, 8'd254, 32'h0);
    queue_request(OP_BODY, 8'd16, 32'h0);
    queue_request(OP_BODY, 8'd1, 32'h0);
    queue_request(OP_BODY, 8'h55, 32'h0);
    queue_request(OP_BODY, 8'd254, 32'h0);
    queue_request(OP_BODY, 8'd254, 32'h0);
    queue_request(OP_BODY, 8'd1, 32'h0);
    queue_request(OP_BODY, 8'd0, 32'h0);
    queue_request(OP_BODY, 8'd255, 32'h0);

    // Random sprites under extreme and random register settings
    configure(1, 1, 255, 254);
    random_phase();
    configure(MAX_WIDTH, 4096, 0, 255);
    random_phase();
    configure(7, 3, 200, 200);
    random_phase();
    configure(16, 8, 255, 254);
    random_phase();
    repeat (4) begin
      configure($urandom_range(1, 64), $urandom_range(1, 16),
                $urandom_range(0, 255), $urandom_range(0, 255));
      random_phase();
    end

    // Hold results off for a long stretch while requests keep coming
    configure(32, 8, 255, 254);
    sender_calm = 1'b1;
    receiver_calm = 1'b0;
    long_hold_tog = ~long_hold_tog;
    repeat (12) gen_sprite(2, 2, 8, 4);

    // Pause the sender until every result is in, then saturate the column
    configure(MAX_WIDTH, 4096, 255, 254);
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    while (parse_phase != WANT_RUN) queue_request(OP_BODY, 8'd0, $urandom());
    queue_request(OP_BODY, cfg_end_code, $urandom());
    repeat (33) begin
      queue_request(OP_BODY, 8'd253, $urandom());
      queue_request(OP_BODY, 8'd0, $urandom());
    end
    queue_request(OP_BODY, 8'd1, $urandom());
    queue_request(OP_BODY, 8'd1, $urandom());
    queue_request(OP_BODY, 8'd255, $urandom());
    repeat (6) queue_request(OP_BODY, cfg_eor_code, $urandom());
    // a short segment a few rows down
    queue_request(OP_BODY, 8'd10, $urandom());
    queue_request(OP_BODY, 8'd2, $urandom());
    queue_request(OP_BODY, 8'd0, $urandom());
    queue_request(OP_BODY, 8'hAA, $urandom());
    queue_request(OP_BODY, cfg_end_code, $urandom());

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
